// ===== design/perimeter_progress_timer_assert.svh =====
// Assertion macros for the perimeter progress timer checker.
`ifndef PERIMETER_PROGRESS_TIMER_ASSERT_SVH
`define PERIMETER_PROGRESS_TIMER_ASSERT_SVH

// Same-cycle implication, gated off while in reset
`define PPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off while in reset
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ppt_pkg.sv =====
// Shared types, constants and ring-mask function for the perimeter progress timer.
package ppt_pkg;

  localparam int ROWS      = 16;
  localparam int COUNT_W   = 36;               // elapsed and duration counters
  localparam int NDOT_W    = 8;                // ring length, 0..156
  localparam int PROD_W    = COUNT_W + NDOT_W; // 156 * elapsed
  localparam int DIV_STEPS = NDOT_W;           // one quotient bit per step
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int ROW_W     = 64;

  localparam logic [NDOT_W-1:0]  RING_DOTS = 8'd156;
  localparam logic [19:0]        US_PER_S  = 20'd1000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Item commands carried in tuser
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_RENDER = 2'd2
  } cmd_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture accepted item
    logic exec;      // apply command to timer state
    logic mul;       // form 156 * elapsed, prime divider
    logic div_step;  // one restoring divide step
    logic emit;      // load output register
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;  // render with timer still running
    logic out_free;  // output register can take a result
  } stat_t;

  // Ring bits of one panel row when the first n ring dots are lit.
  // Each bit has a fixed position along the ring; it is lit when that
  // position is below n.
  function automatic logic [ROW_W-1:0] ring_row_bits(input logic [3:0] row,
                                                     input logic [NDOT_W-1:0] n);
    logic [ROW_W-1:0]  bits;
    logic [NDOT_W-1:0] pos;
    bits = '0;
    for (int b = 0; b < ROW_W; b++) begin
      if (b == 0) begin
        pos = {4'd0, row};                          // right column, going up
      end else if (b == ROW_W - 1) begin
        pos = 8'd93 - {4'd0, row};                  // left column, going down
      end else if (row == 4'(ROWS - 1)) begin
        pos = 8'(b) + 8'd15;                        // top row, going left
      end else if (row == 4'd0) begin
        pos = RING_DOTS - 8'(b);                    // bottom row, going right
      end else begin
        pos = 8'hFF;                                // interior: never lit
      end
      bits[b] = (pos < n);
    end
    return bits;
  endfunction

endpackage

// ===== design/ppt_ctrl.sv =====
// Sequencing state machine for the perimeter progress timer.
module ppt_ctrl
  import ppt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output ctrl_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_div ? S_MUL : S_EMIT;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== design/ppt_datapath.sv =====
// Timer state, ring-length divider and output register of the perimeter progress timer.
module ppt_datapath
  import ppt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_t            cmd,
  output stat_t            stat,
  input  logic [1:0]       command,
  input  logic [15:0]      duration_s,
  input  logic [15:0]      tick_us,
  input  logic [3:0]       row_index,
  input  logic [ROW_W-1:0] row_in,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [ROW_W-1:0] row_out,
  output logic             expired,
  output logic             running
);

  // Captured item
  cmd_t             cmd_r;
  logic [15:0]      dur_s_r;
  logic [15:0]      tick_r;
  logic [3:0]       row_idx_r;
  logic [ROW_W-1:0] row_in_r;

  // Timer state
  logic               run_r, run_nxt;
  logic [COUNT_W-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_W-1:0] duration_r, duration_nxt;
  logic               expired_r, expired_nxt;

  // Divider
  logic [PROD_W-1:0]   rem_r, rem_nxt;
  logic [PROD_W-2:0]   dsh_r, dsh_nxt;
  logic [NDOT_W-1:0]   ndots_r, ndots_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] out_row_r;
  logic             out_exp_r;
  logic             out_run_r;

  logic               done;
  logic [COUNT_W:0]   tick_sum;
  logic [COUNT_W-1:0] dur_us;
  logic [PROD_W-1:0]  trial;

  assign done     = (elapsed_r >= duration_r);
  assign tick_sum = {1'b0, elapsed_r} + {{(COUNT_W - 16 + 1){1'b0}}, tick_r};
  assign dur_us   = {{(COUNT_W - 16){1'b0}}, dur_s_r} * {{(COUNT_W - 20){1'b0}}, US_PER_S};
  assign trial    = rem_r - {1'b0, dsh_r};

  assign stat.need_div = (cmd_r == CMD_RENDER) && run_r && !done;
  assign stat.out_free = !out_valid_r || out_tready;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= cmd_t'(command);
      dur_s_r   <= duration_s;
      tick_r    <= tick_us;
      row_idx_r <= row_index;
      row_in_r  <= row_in;
    end
  end

  // Command execution and ring-length divide
  always_comb begin
    run_nxt      = run_r;
    elapsed_nxt  = elapsed_r;
    duration_nxt = duration_r;
    expired_nxt  = expired_r;
    rem_nxt      = rem_r;
    dsh_nxt      = dsh_r;
    ndots_nxt    = ndots_r;
    if (cmd.exec) begin
      expired_nxt = 1'b0;
      case (cmd_r)
        CMD_START: begin
          duration_nxt = dur_us;
          elapsed_nxt  = '0;
          run_nxt      = 1'b1;
        end
        CMD_TICK: begin
          elapsed_nxt = tick_sum[COUNT_W] ? COUNT_MAX : tick_sum[COUNT_W-1:0];
        end
        CMD_RENDER: begin
          if (run_r && done) begin
            run_nxt     = 1'b0;
            expired_nxt = 1'b1;
          end
          ndots_nxt = RING_DOTS;   // full ring unless the divider overwrites it
        end
        default: begin
        end
      endcase
    end
    // Quotient fits in NDOT_W bits because elapsed < duration here
    if (cmd.mul) begin
      rem_nxt   = {{NDOT_W{1'b0}}, elapsed_r} * {{COUNT_W{1'b0}}, RING_DOTS};
      dsh_nxt   = {duration_r, {(NDOT_W - 1){1'b0}}};
      ndots_nxt = '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= {1'b0, dsh_r}) begin
        rem_nxt   = trial;
        ndots_nxt = {ndots_r[NDOT_W-2:0], 1'b1};
      end else begin
        ndots_nxt = {ndots_r[NDOT_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      elapsed_r  <= '0;
      duration_r <= '0;
    end else begin
      run_r      <= run_nxt;
      elapsed_r  <= elapsed_nxt;
      duration_r <= duration_nxt;
    end
  end

  always_ff @(posedge clk) begin
    expired_r <= expired_nxt;
    rem_r     <= rem_nxt;
    dsh_r     <= dsh_nxt;
    ndots_r   <= ndots_nxt;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r <= (cmd_r == CMD_RENDER) ? (row_in_r | ring_row_bits(row_idx_r, ndots_r))
                                         : '0;
      out_exp_r <= expired_r;
      out_run_r <= run_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign row_out    = out_row_r;
  assign expired    = out_exp_r;
  assign running    = out_run_r;

endmodule

// ===== design/perimeter_progress_timer.sv =====
// Top level of the perimeter progress timer: stream ports, controller and datapath.
//
// Countdown timer that draws its progress as a ring of dots round the edge of a
// 16 x 64 dot panel. One item is in flight at a time. Start, tick and unused
// command codes, and renders that find the timer idle or just expired, pass
// through the execute and emit states before the next item can be taken; a
// render while the timer is still counting also passes through a multiply
// state and the divide states, in which a restoring divider produces the ring
// length floor(156 * elapsed / duration) one quotient bit per cycle. Each result
// goes into an output register, so the block takes the next item while the
// previous result is still waiting for out_tready; it stalls only when a second
// result is ready before the first has gone. No clearing pass after reset.
module perimeter_progress_timer
  import ppt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // command
  input  logic [103:0] in_tdata,   // duration_s, tick_us, row_index, row_in, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata   // row_out, expired, running, zero pad
);

  ctrl_t            cmd;
  stat_t            stat;
  logic [ROW_W-1:0] row_out;
  logic             expired;
  logic             running;

  ppt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ppt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .command    (in_tuser),
    .duration_s (in_tdata[15:0]),
    .tick_us    (in_tdata[31:16]),
    .row_index  (in_tdata[35:32]),
    .row_in     (in_tdata[99:36]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .row_out    (row_out),
    .expired    (expired),
    .running    (running)
  );

  assign out_tdata = {6'd0, running, expired, row_out};

endmodule

// ===== design/ppt_checker.sv =====
// Port-level checker for the perimeter progress timer, bound to the top level.
`include "perimeter_progress_timer_assert.svh"

module ppt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  logic in_acc;
  logic out_wait;
  logic out_exp;
  logic out_run;
  assign in_acc   = in_tvalid && in_tready;
  assign out_wait = out_tvalid && !out_tready;
  assign out_exp  = out_tvalid && out_tdata[64];
  assign out_run  = out_tdata[65];

  // A held result keeps its payload
  `PPT_ASSERT_NEXT(a_out_hold, out_wait, out_tvalid && $stable(out_tdata), "held result changed")

  // Expiry always stops the timer
  `PPT_ASSERT_NOW(a_exp_stops, out_exp, !out_run, "expired result still running")

  // One item at a time: no new item straight after an accepted one
  `PPT_ASSERT_NEXT(a_one_item, in_acc, !in_tready, "item accepted while one in flight")

  // A result never appears the cycle after acceptance
  `PPT_ASSERT_NEXT(a_min_lat, in_acc && !out_tvalid, !out_tvalid, "result too early")

endmodule

bind perimeter_progress_timer ppt_checker u_ppt_checker (.*);
